// File: rtl/core/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared constants and types for the deframer core: link byte codes,
// CRC-16/CCITT constants, status codes and the CRC unit control word.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  ESC_XOR     = 8'h20;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam int          CAP_W       = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [2:0]  ST_OK       = 3'd0;
    localparam logic [2:0]  ST_TOO_LONG = 3'd1;
    localparam logic [2:0]  ST_DANGLING = 3'd2;
    localparam logic [2:0]  ST_TOO_SHORT= 3'd3;
    localparam logic [2:0]  ST_CRC_BAD  = 3'd4;
    localparam logic [2:0]  ST_OVER_CAP = 3'd5;

    typedef struct packed {
        logic       start;  // fold data_byte into the running CRC
        logic       clear;  // back to init value
        logic [7:0] data_byte;
    } crc_ctl_t;

endpackage

// File: rtl/core/ash_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// ash_frame_decoder_core
// ASH deframer: byte unstuffing, CRC-16/CCITT check and frame drain.
//
//  channel   | dir | words                     | tdata / tuser
//  s_axis    | in  | raw link bytes            | tdata[7:0] raw_byte
//  m_axis    | out | control, payload or error | tdata[7:0] out_byte,
//            |     |                           | tuser[0] is_control,
//            |     |                           | tuser[3:1] status
//  cfg       | in  | payload_capacity write    | cfg_wdata[5:0]
//
// A data byte waits in S_CRC while the bit-serial CRC unit runs 8 steps.
// An escape byte only sets the escape flag. At a flag, the frame is checked;
// then each drained byte goes through a store read, then an output load.
// Output stalls hold the drain; the output register frees the input side
// as soon as the last word of a frame is loaded.
// Reset clears control state and the CRC; the store needs no clearing.
// ----------------------------------------------------------------------------
module ash_frame_decoder_core
    import afd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] raw_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]       m_axis_tuser,   // [0] is_control, [3:1] status
    output logic             m_axis_tlast,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    localparam int DEPTH = MAX_PAYLOAD + 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CRC   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             esc_reg, esc_next;
    logic             ovf_reg, ovf_next;
    logic [CAP_W-1:0] cap_reg;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_ctl_reg, out_ctl_next;
    logic             out_last_reg, out_last_next;
    logic [2:0]       out_status_reg, out_status_next;

    crc_ctl_t         crc_ctl;
    logic             crc_busy;
    logic [15:0]      crc_val;

    logic             mem_we;
    logic [7:0]       rd_data;
    logic [7:0]       unstuffed;
    logic [CW-1:0]    plen;
    logic [2:0]       status;
    logic             in_take;
    logic             out_free;

    afd_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .busy  (crc_busy),
        .crc   (crc_val)
    );

    afd_frame_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (unstuffed),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign unstuffed     = esc_reg ? (s_axis_tdata ^ ESC_XOR) : s_axis_tdata;
    assign plen          = count_reg - CW'(3);

    always_comb
    begin
        if (ovf_reg)
            status = ST_TOO_LONG;
        else if (esc_reg)
            status = ST_DANGLING;
        else if (count_reg < CW'(3))
            status = ST_TOO_SHORT;
        else if (crc_val != 16'h0000)
            status = ST_CRC_BAD;
        else if (8'(plen) > 8'(cap_reg))
            status = ST_OVER_CAP;
        else
            status = ST_OK;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        esc_next        = esc_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_ctl_next    = out_ctl_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        crc_ctl         = '{start: 1'b0, clear: 1'b0, data_byte: unstuffed};
        mem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (s_axis_tdata == FLAG_BYTE)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (!esc_reg && s_axis_tdata == ESC_BYTE)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        esc_next      = 1'b0;
                        crc_ctl.start = 1'b1;
                        state_next    = S_CRC;
                        if (count_reg >= CW'(DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            S_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                idx_next = '0;
                if (status == ST_OK)
                begin
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = 8'h00;
                    out_ctl_next    = 1'b0;
                    out_last_next   = 1'b1;
                    out_status_next = status;
                    count_next      = '0;
                    esc_next        = 1'b0;
                    ovf_next        = 1'b0;
                    crc_ctl.clear   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = rd_data;
                    out_ctl_next    = (idx_reg == '0);
                    out_last_next   = (idx_reg == plen);
                    out_status_next = ST_OK;
                    if (idx_reg == plen)
                    begin
                        count_next    = '0;
                        esc_next      = 1'b0;
                        ovf_next      = 1'b0;
                        crc_ctl.clear = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            esc_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            esc_reg       <= esc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_ctl_reg    <= out_ctl_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_status_reg, out_ctl_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/core/afd_crc_unit.sv
// ----------------------------------------------------------------------------
// afd_crc_unit
// Bit-serial CRC-16/CCITT, MSB first: one shift/XOR step per cycle,
// one step per bit of the byte. Holds the running CRC of the current frame.
// ----------------------------------------------------------------------------
module afd_crc_unit
    import afd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctl_t    ctl,
    output logic        busy,
    output logic [15:0] crc
);

    logic [15:0] crc_reg, crc_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        busy_reg, busy_next;

    always_comb
    begin
        crc_next     = crc_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        if (ctl.clear)
        begin
            crc_next  = CRC_INIT;
            busy_next = 1'b0;
        end
        else if (ctl.start)
        begin
            crc_next     = crc_reg ^ {ctl.data_byte, 8'h00};
            bit_cnt_next = 3'd0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next     = crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ CRC_POLY)
                                       : {crc_reg[14:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 3'd1;
            if (bit_cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            bit_cnt_reg <= 3'd0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            crc_reg     <= crc_next;
            bit_cnt_reg <= bit_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

// File: rtl/core/afd_frame_store.sv
// ----------------------------------------------------------------------------
// afd_frame_store
// Byte store for one frame: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module afd_frame_store #(
    parameter int DEPTH = 35
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
